// ----- design/hbcs_pkg.sv -----
// Shared types, codes and the six-step drive table of the hall commutator.
package hbcs_pkg;

	// Widths of the fields and of internal values.
	localparam int unsigned CMP_W    = 16;
	localparam int unsigned SPEED_W  = 22;
	localparam int unsigned SUM_W    = 18;
	localparam int unsigned DIVISOR_W = 18;
	localparam int unsigned SLOTS    = 4;
	localparam int unsigned SLOT_W   = 2;

	// Speed numerator, also the saturated result on a zero divisor.
	localparam logic [SPEED_W-1:0] SPEED_NUM = SPEED_W'(2500000);

	// Item kinds.
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_STOP   = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MIN_DUTY     = 2'd0;
	localparam logic [1:0] CFG_FULL_COMPARE = 2'd1;
	localparam logic [1:0] CFG_REVERSE_DIR  = 2'd2;
	localparam logic [1:0] CFG_EDGE_SKIP    = 2'd3;

	// Phase drive modes.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_OFF = 2'd0;
	localparam mode_t MODE_LOW = 2'd1;
	localparam mode_t MODE_PWM = 2'd2;

	// Element 0 is phase 1.
	typedef mode_t [2:0] modes_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_DIV
	} state_t;

	// Drive pattern for a hall code; codes 0 and 7 map to all off.
	function automatic modes_t step_modes(input logic dir, input logic [2:0] code);
		modes_t m;
		m = '{MODE_OFF, MODE_OFF, MODE_OFF};
		if (!dir) begin
			unique case (code)
				3'd1: m = '{MODE_LOW, MODE_PWM, MODE_OFF};
				3'd2: m = '{MODE_OFF, MODE_LOW, MODE_PWM};
				3'd3: m = '{MODE_LOW, MODE_OFF, MODE_PWM};
				3'd4: m = '{MODE_PWM, MODE_OFF, MODE_LOW};
				3'd5: m = '{MODE_OFF, MODE_PWM, MODE_LOW};
				3'd6: m = '{MODE_PWM, MODE_LOW, MODE_OFF};
				default: m = '{MODE_OFF, MODE_OFF, MODE_OFF};
			endcase
		end else begin
			unique case (code)
				3'd1: m = '{MODE_PWM, MODE_LOW, MODE_OFF};
				3'd2: m = '{MODE_OFF, MODE_PWM, MODE_LOW};
				3'd3: m = '{MODE_PWM, MODE_OFF, MODE_LOW};
				3'd4: m = '{MODE_LOW, MODE_OFF, MODE_PWM};
				3'd5: m = '{MODE_OFF, MODE_LOW, MODE_PWM};
				3'd6: m = '{MODE_LOW, MODE_PWM, MODE_OFF};
				default: m = '{MODE_OFF, MODE_OFF, MODE_OFF};
			endcase
		end
		return m;
	endfunction

endpackage

// ----- design/hbcs_div.sv -----
// Bit-serial restoring divider for the speed numerator, one quotient bit per cycle.
module hbcs_div
	import hbcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [SPEED_W-1:0]   quotient
);

	localparam int unsigned CNT_W = $clog2(SPEED_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [SPEED_W-1:0]   nq_q;
	logic [DIVISOR_W:0]   shifted;
	logic                 qbit;

	// Bring down the next numerator bit and trial-subtract the divisor.
	assign shifted = {rem_q, nq_q[SPEED_W-1]};
	assign qbit    = (shifted >= {1'b0, div_q});

	// Control: counter, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SPEED_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and the numerator/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			nq_q  <= SPEED_NUM;
		end else if (busy_q) begin
			if (qbit) begin
				rem_q <= DIVISOR_W'(shifted - {1'b0, div_q});
			end else begin
				rem_q <= shifted[DIVISOR_W-1:0];
			end
			nq_q <= {nq_q[SPEED_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

// ----- design/hall_bldc_commutation_speed_top.sv -----
// Six-step hall commutator with interval capture and serial speed division.
// An accepted item goes through CALC and into the output register; an item that closes
// a group of four intervals first goes through the interval scan (SCAN), a setup step
// in CALC and, on a nonzero divisor, the bit-serial divide (DIV). The input stalls until
// the item is handed over; a finished result waits in the output register. Reset (arst_n low)
// stops the motor, turns the held phase modes off and clears control and motor state.
module hall_bldc_commutation_speed_top
	import hbcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Item channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [2:0]         hall_code,
	input  logic [CMP_W-1:0]   elapsed_ticks,
	input  logic [CMP_W-1:0]   duty,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         ch1_mode,
	output logic [1:0]         ch2_mode,
	output logic [1:0]         ch3_mode,
	output logic [CMP_W-1:0]   ch1_compare,
	output logic [CMP_W-1:0]   ch2_compare,
	output logic [CMP_W-1:0]   ch3_compare,
	output logic [SPEED_W-1:0] speed_value,
	output logic               running,
	output logic               speed_fresh,
	output logic               commutated,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CMP_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [CMP_W-1:0] min_duty_q;
	logic [CMP_W-1:0] full_compare_q;
	logic             reverse_dir_q;
	logic [7:0]       edge_skip_q;

	// Motor state.
	state_t               state_q, state_d;
	logic                 run_q;
	logic [2:0]           last_pos_q;
	logic [CMP_W-1:0]     interval_q;
	logic [CMP_W-1:0]     store_q [SLOTS];
	logic [SLOT_W-1:0]    slot_q;
	logic [7:0]           edge_cnt_q;
	logic [SPEED_W-1:0]   speed_q;
	modes_t               modes_q;
	logic [CMP_W-1:0]     cmp_q [3];
	logic                 fresh_q;
	logic                 comm_q;

	// Interval scan registers.
	logic [SLOT_W-1:0]    scan_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CMP_W-1:0]     min_q;
	logic [CMP_W-1:0]     max_q;

	// Output register.
	logic                 out_valid_q;
	modes_t               out_modes_q;
	logic [CMP_W-1:0]     out_cmp_q [3];
	logic [SPEED_W-1:0]   out_speed_q;
	logic                 out_run_q;
	logic                 out_fresh_q;
	logic                 out_comm_q;

	logic                 in_accept;
	logic                 out_take;
	logic                 result_load;
	logic                 is_edge;
	logic                 code_ok;
	logic [CMP_W-1:0]     interval_sum;
	logic [7:0]           edge_next;
	logic                 edge_fire;
	modes_t               new_modes;
	logic [CMP_W-1:0]     pwm_cmp;
	logic [CMP_W-1:0]     scan_val;
	logic [SUM_W-2:0]     mid_sum;
	logic [DIVISOR_W-1:0] divisor;
	logic                 div_start;
	logic                 div_done;
	logic [SPEED_W-1:0]   quotient;

	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	// Decode of the accepted item.
	assign interval_sum = interval_q + elapsed_ticks;
	assign is_edge      = (kind == KIND_SAMPLE) && run_q && (hall_code != last_pos_q);
	assign edge_next    = edge_cnt_q + 8'd1;
	assign edge_fire    = edge_next > edge_skip_q;
	assign code_ok      = (hall_code != 3'd0) && (hall_code != 3'd7);
	assign new_modes    = step_modes((kind == KIND_START) ? 1'b0 : reverse_dir_q, hall_code);
	assign pwm_cmp      = (kind == KIND_START) ? min_duty_q : duty;

	// Middle two of four intervals: total minus the smallest and the largest.
	assign scan_val = store_q[scan_q];
	assign mid_sum  = (SUM_W-1)'(sum_q - SUM_W'(min_q) - SUM_W'(max_q));
	assign divisor  = {mid_sum, 1'b0};

	// Next state; a result is handed over once the output register is free.
	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && is_edge && (slot_q == SLOT_W'(SLOTS - 1))) begin
					state_d = ST_SCAN;
				end else if (in_accept) begin
					state_d = ST_CALC;
				end
			end
			ST_SCAN: begin
				if (scan_q == SLOT_W'(SLOTS - 1)) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (fresh_q && divisor != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (!out_valid_q || !out_stall) begin
					result_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CALC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q     <= '0;
			full_compare_q <= '1;
			reverse_dir_q  <= 1'b1;
			edge_skip_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_DUTY:     min_duty_q     <= cfg_data;
				CFG_FULL_COMPARE: full_compare_q <= cfg_data;
				CFG_REVERSE_DIR:  reverse_dir_q  <= cfg_data[0];
				CFG_EDGE_SKIP:    edge_skip_q    <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	// Motor state update on an accepted item, speed update after the divide or on a zero divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			last_pos_q <= '0;
			interval_q <= '0;
			for (int i = 0; i < SLOTS; i++) store_q[i] <= '0;
			slot_q     <= '0;
			edge_cnt_q <= '0;
			speed_q    <= '0;
			modes_q    <= '{MODE_OFF, MODE_OFF, MODE_OFF};
			for (int i = 0; i < 3; i++) cmp_q[i] <= '0;
			fresh_q    <= 1'b0;
			comm_q     <= 1'b0;
		end else begin
			if (in_accept) begin
				fresh_q    <= 1'b0;
				comm_q     <= 1'b0;
				interval_q <= interval_sum;
				if (kind == KIND_START) begin
					run_q      <= 1'b1;
					last_pos_q <= hall_code;
					if (code_ok) begin
						comm_q  <= 1'b1;
						modes_q <= new_modes;
						for (int i = 0; i < 3; i++) begin
							cmp_q[i] <= (new_modes[i] == MODE_LOW) ? full_compare_q : pwm_cmp;
						end
					end
				end else if (kind == KIND_STOP) begin
					run_q   <= 1'b0;
					modes_q <= '{MODE_OFF, MODE_OFF, MODE_OFF};
					for (int i = 0; i < 3; i++) cmp_q[i] <= '0;
				end else if (is_edge) begin
					store_q[slot_q] <= interval_sum;
					slot_q          <= slot_q + SLOT_W'(1);
					fresh_q         <= (slot_q == SLOT_W'(SLOTS - 1));
					interval_q      <= '0;
					if (edge_fire) begin
						edge_cnt_q <= '0;
						last_pos_q <= hall_code;
						if (code_ok) begin
							comm_q  <= 1'b1;
							modes_q <= new_modes;
							for (int i = 0; i < 3; i++) begin
								cmp_q[i] <= (new_modes[i] == MODE_LOW) ? full_compare_q : pwm_cmp;
							end
						end
					end else begin
						edge_cnt_q <= edge_next;
					end
				end
			end
			// A zero divisor saturates; otherwise the quotient lands after the divide.
			if (state_q == ST_CALC && fresh_q && divisor == '0) begin
				speed_q <= SPEED_NUM;
			end
			if (state_q == ST_DIV && div_done) begin
				speed_q <= quotient;
				fresh_q <= 1'b0;
			end
		end
	end

	// Walk the four stored intervals, tracking total, minimum and maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + SLOT_W'(1);
		end else begin
			scan_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			if (scan_q == '0) begin
				sum_q <= SUM_W'(scan_val);
				min_q <= scan_val;
				max_q <= scan_val;
			end else begin
				sum_q <= sum_q + SUM_W'(scan_val);
				if (scan_val < min_q) min_q <= scan_val;
				if (scan_val > max_q) max_q <= scan_val;
			end
		end
	end

	// The fresh flag for the result is captured when the item is accepted; keep it once the
	// divide has cleared its working copy.
	logic fresh_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_seen_q <= 1'b0;
		end else if (in_accept) begin
			fresh_seen_q <= is_edge && (kind == KIND_SAMPLE) && (slot_q == SLOT_W'(SLOTS - 1));
		end
	end

	hbcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Output register: loaded with the held state once an item is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_modes_q <= modes_q;
			for (int i = 0; i < 3; i++) out_cmp_q[i] <= cmp_q[i];
			out_speed_q <= (fresh_q && divisor == '0) ? SPEED_NUM : speed_q;
			out_run_q   <= run_q;
			out_fresh_q <= fresh_seen_q;
			out_comm_q  <= comm_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ch1_mode    = out_modes_q[0];
	assign ch2_mode    = out_modes_q[1];
	assign ch3_mode    = out_modes_q[2];
	assign ch1_compare = out_cmp_q[0];
	assign ch2_compare = out_cmp_q[1];
	assign ch3_compare = out_cmp_q[2];
	assign speed_value = out_speed_q;
	assign running     = out_run_q;
	assign speed_fresh = out_fresh_q;
	assign commutated  = out_comm_q;

endmodule

// ----- test/hall_bldc_commutation_speed_checker.sv -----
`timescale 1ns / 100ps
// Checker for the hall commutator: watches all channels, predicts each result and compares.
module hall_bldc_commutation_speed_checker
	import hbcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [2:0]         hall_code,
	input  logic [CMP_W-1:0]   elapsed_ticks,
	input  logic [CMP_W-1:0]   duty,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         ch1_mode,
	input  logic [1:0]         ch2_mode,
	input  logic [1:0]         ch3_mode,
	input  logic [CMP_W-1:0]   ch1_compare,
	input  logic [CMP_W-1:0]   ch2_compare,
	input  logic [CMP_W-1:0]   ch3_compare,
	input  logic [SPEED_W-1:0] speed_value,
	input  logic               running,
	input  logic               speed_fresh,
	input  logic               commutated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CMP_W-1:0]   cfg_data,
	output int                 mismatches,
	output int                 outstanding
);

	// One expected result transaction.
	typedef struct packed {
		mode_t              m1;
		mode_t              m2;
		mode_t              m3;
		logic [CMP_W-1:0]   c1;
		logic [CMP_W-1:0]   c2;
		logic [CMP_W-1:0]   c3;
		logic [SPEED_W-1:0] speed;
		logic               run;
		logic               fresh;
		logic               comm;
	} drive_report_t;

	// Register copies.
	logic [CMP_W-1:0] start_duty;
	logic [CMP_W-1:0] low_cmp;
	logic             ccw;
	logic [7:0]       skip_edges;

	// Commutator and speed state.
	logic               motor_on;
	logic [2:0]         held_hall;
	logic [CMP_W-1:0]   tick_sum;
	logic [CMP_W-1:0]   gap_buf [0:3];
	logic [1:0]         gap_slot;
	logic [7:0]         edge_tally;
	logic [SPEED_W-1:0] rpm;
	mode_t              phase_mode [0:2];
	logic [CMP_W-1:0]   phase_cmp [0:2];

	drive_report_t pending_drive [$];
	drive_report_t oldest;

	// Forward-rotation modes of phases 1..3, phase 1 in the top bits.
	function automatic logic [5:0] forward_pattern(input logic [2:0] code);
		case (code)
			3'd1: return {MODE_OFF, MODE_PWM, MODE_LOW};
			3'd2: return {MODE_PWM, MODE_LOW, MODE_OFF};
			3'd3: return {MODE_PWM, MODE_OFF, MODE_LOW};
			3'd4: return {MODE_LOW, MODE_OFF, MODE_PWM};
			3'd5: return {MODE_LOW, MODE_PWM, MODE_OFF};
			3'd6: return {MODE_OFF, MODE_LOW, MODE_PWM};
			default: return {MODE_OFF, MODE_OFF, MODE_OFF};
		endcase
	endfunction

	// Apply a six-step pattern; the reverse rotation equals the forward pattern of the
	// complemented hall code. Codes 0 and 7 have no pattern and leave the drive alone.
	function automatic logic drive_step(input logic rev, input logic [2:0] code,
			input logic [CMP_W-1:0] pwm);
		logic [5:0] pat;
		if (code == 3'd0 || code == 3'd7)
			return 1'b0;
		pat = forward_pattern(rev ? ~code : code);
		for (int i = 0; i < 3; i++) begin
			phase_mode[i] = pat[5-2*i -: 2];
			phase_cmp[i] = (phase_mode[i] == MODE_LOW) ? low_cmp : pwm;
		end
		return 1'b1;
	endfunction

	// Sort the four intervals in place and divide by twice the sum of the middle two.
	function automatic logic [SPEED_W-1:0] measured_speed();
		logic [CMP_W-1:0] t;
		logic [31:0] div;
		logic [31:0] quot;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 3 - i; j++) begin
				if (gap_buf[j] > gap_buf[j+1]) begin
					t = gap_buf[j];
					gap_buf[j] = gap_buf[j+1];
					gap_buf[j+1] = t;
				end
			end
		end
		div = ({16'd0, gap_buf[1]} + {16'd0, gap_buf[2]}) << 1;
		if (div == 0)
			return SPEED_NUM;
		quot = SPEED_NUM / div;
		return quot[SPEED_W-1:0];
	endfunction

	// Advance the commutator by one input transaction and report the held outputs.
	function automatic drive_report_t commutate_and_time(input logic [1:0] k,
			input logic [2:0] h, input logic [CMP_W-1:0] t, input logic [CMP_W-1:0] d);
		drive_report_t r;
		logic fresh;
		logic comm;
		fresh = 1'b0;
		comm = 1'b0;
		tick_sum = tick_sum + t;
		case (k)
			KIND_START: begin
				comm = drive_step(1'b0, h, start_duty);
				held_hall = h;
				motor_on = 1'b1;
			end
			KIND_STOP: begin
				for (int i = 0; i < 3; i++) begin
					phase_mode[i] = MODE_OFF;
					phase_cmp[i] = '0;
				end
				motor_on = 1'b0;
			end
			KIND_SAMPLE: begin
				// Only a real hall edge while running is timed and counted.
				if (motor_on && h != held_hall) begin
					gap_buf[gap_slot] = tick_sum;
					gap_slot = gap_slot + 2'd1;
					if (gap_slot == 2'd0) begin
						rpm = measured_speed();
						fresh = 1'b1;
					end
					tick_sum = '0;
					edge_tally = edge_tally + 8'd1;
					if (edge_tally > skip_edges) begin
						edge_tally = '0;
						comm = drive_step(ccw, h, d);
						held_hall = h;
					end
				end
			end
			default: ;
		endcase
		r.m1 = phase_mode[0];
		r.m2 = phase_mode[1];
		r.m3 = phase_mode[2];
		r.c1 = phase_cmp[0];
		r.c2 = phase_cmp[1];
		r.c3 = phase_cmp[2];
		r.speed = rpm;
		r.run = motor_on;
		r.fresh = fresh;
		r.comm = comm;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare accepted results first, then pick up register writes and new transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_duty = '0;
			low_cmp = 16'hFFFF;
			ccw = 1'b1;
			skip_edges = '0;
			motor_on = 1'b0;
			held_hall = '0;
			tick_sum = '0;
			gap_slot = '0;
			edge_tally = '0;
			rpm = '0;
			for (int i = 0; i < 4; i++)
				gap_buf[i] = '0;
			for (int i = 0; i < 3; i++) begin
				phase_mode[i] = MODE_OFF;
				phase_cmp[i] = '0;
			end
			pending_drive.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_drive.size() == 0) begin
					$error("result transaction with no input transaction pending");
					mismatches++;
				end else begin
					oldest = pending_drive.pop_front();
					check_field("ch1_mode", 32'(oldest.m1), 32'(ch1_mode));
					check_field("ch2_mode", 32'(oldest.m2), 32'(ch2_mode));
					check_field("ch3_mode", 32'(oldest.m3), 32'(ch3_mode));
					check_field("ch1_compare", 32'(oldest.c1), 32'(ch1_compare));
					check_field("ch2_compare", 32'(oldest.c2), 32'(ch2_compare));
					check_field("ch3_compare", 32'(oldest.c3), 32'(ch3_compare));
					check_field("speed_value", 32'(oldest.speed), 32'(speed_value));
					check_field("running", 32'(oldest.run), 32'(running));
					check_field("speed_fresh", 32'(oldest.fresh), 32'(speed_fresh));
					check_field("commutated", 32'(oldest.comm), 32'(commutated));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_DUTY:     start_duty = cfg_data;
					CFG_FULL_COMPARE: low_cmp = cfg_data;
					CFG_REVERSE_DIR:  ccw = cfg_data[0];
					CFG_EDGE_SKIP:    skip_edges = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_drive.push_back(commutate_and_time(kind, hall_code, elapsed_ticks, duty));
			outstanding = pending_drive.size();
		end
	end

endmodule

// ----- test/hall_bldc_commutation_speed_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the hall commutator: stimulus, channel idling and the final verdict.
module hall_bldc_commutation_speed_top_tb;
	import hbcs_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [2:0]         hall_code;
	logic [CMP_W-1:0]   elapsed_ticks;
	logic [CMP_W-1:0]   duty;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         ch1_mode;
	logic [1:0]         ch2_mode;
	logic [1:0]         ch3_mode;
	logic [CMP_W-1:0]   ch1_compare;
	logic [CMP_W-1:0]   ch2_compare;
	logic [CMP_W-1:0]   ch3_compare;
	logic [SPEED_W-1:0] speed_value;
	logic               running;
	logic               speed_fresh;
	logic               commutated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [CMP_W-1:0]   cfg_data;
	int                 mismatches;
	int                 outstanding;

	logic        no_gaps;
	int unsigned stall_left = 0;

	hall_bldc_commutation_speed_top dut (.*);
	hall_bldc_commutation_speed_checker scoreboard (.*);

	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 96)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Valid hall codes in rotation order.
	function automatic logic [2:0] hall_at(input int pos);
		case (pos)
			0: return 3'd1;
			1: return 3'd3;
			2: return 3'd2;
			3: return 3'd6;
			4: return 3'd4;
			default: return 3'd5;
		endcase
	endfunction

	function automatic logic [2:0] any_code();
		return 3'($urandom_range(7));
	endfunction

	// Tick scale per run: mostly zero, small, medium or full range.
	function automatic logic [CMP_W-1:0] ticks_for(input int unsigned scale);
		case (scale)
			0: return ($urandom_range(7) == 0) ? CMP_W'($urandom_range(65535)) : '0;
			1: return CMP_W'($urandom_range(40));
			2: return CMP_W'($urandom_range(20000, 300));
			default: return CMP_W'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [CMP_W-1:0] any_duty();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 16'hFFFF;
		return CMP_W'($urandom);
	endfunction

	// Result side stall: stalls and the free flow in between are mostly short, now and then long.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left <= ($urandom_range(6) == 0) ? $urandom_range(150, 40) : $urandom_range(8);
		end else begin
			out_stall <= 1'b1;
			stall_left <= idle_span();
		end
	end

	// Offer one input transaction after an optional gap and wait until it is taken.
	task automatic put_item(input logic [1:0] k, input logic [2:0] h,
			input logic [CMP_W-1:0] t, input logic [CMP_W-1:0] d);
		int unsigned gap;
		gap = no_gaps ? 0 : idle_span();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		hall_code <= h;
		elapsed_ticks <= t;
		duty <= d;
		do @(posedge clk); while (in_stall);
	endtask

	// Let every pending result drain, then give the divider time to go quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CMP_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [CMP_W-1:0] min_d, input logic [CMP_W-1:0] full_c,
			input logic rev, input logic [7:0] skip);
		write_reg(CFG_MIN_DUTY, min_d);
		write_reg(CFG_FULL_COMPARE, full_c);
		write_reg(CFG_REVERSE_DIR, {15'd0, rev});
		write_reg(CFG_EDGE_SKIP, {8'd0, skip});
		cfg_valid <= 1'b0;
	endtask

	// Motor runs: a start, then mostly clean hall rotation with random timing, mixed with
	// repeated codes, noise codes, restarts, stops and unused kinds.
	task automatic run_motor(input int unsigned count);
		int unsigned sent;
		int unsigned seg_len;
		int unsigned step_no;
		int unsigned r;
		int unsigned scale;
		int pos;
		int stride;
		sent = 0;
		while (sent < count) begin
			scale = $urandom_range(3);
			no_gaps = ($urandom_range(4) == 0);
			pos = $urandom_range(5);
			stride = $urandom_range(1) ? 1 : 5;
			seg_len = $urandom_range(40, 8);
			put_item(KIND_START, ($urandom_range(9) == 0) ? 3'd7 : hall_at(pos),
				ticks_for(scale), any_duty());
			sent++;
			for (step_no = 0; step_no < seg_len && sent < count; step_no++) begin
				r = $urandom_range(99);
				if (r < 72) begin
					if ($urandom_range(15) == 0)
						stride = 6 - stride;
					pos = (pos + stride) % 6;
					put_item(KIND_SAMPLE, hall_at(pos), ticks_for(scale), any_duty());
				end else if (r < 80) begin
					put_item(KIND_SAMPLE, hall_at(pos), ticks_for(scale), any_duty());
				end else if (r < 87) begin
					put_item(KIND_SAMPLE, any_code(), ticks_for(scale), any_duty());
				end else if (r < 91) begin
					put_item(KIND_SPARE, any_code(), ticks_for(scale), any_duty());
				end else if (r < 95) begin
					put_item(KIND_START, any_code(), ticks_for(scale), any_duty());
				end else begin
					put_item(KIND_STOP, any_code(), ticks_for(scale), any_duty());
				end
				sent++;
			end
			if (sent < count && $urandom_range(1)) begin
				put_item(KIND_STOP, any_code(), ticks_for(scale), any_duty());
				sent++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_START;
		hall_code = '0;
		elapsed_ticks = '0;
		duty = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_DUTY;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset register values: stopped samples, unused kind,
		// invalid codes on start and sample, restart, zero divisor, wrap of the tick sum.
		put_item(KIND_SAMPLE, 3'd1, 16'hFFFF, 16'h1234);
		put_item(KIND_SPARE,  3'd2, 16'd1,    16'hFFFF);
		put_item(KIND_START,  3'd0, 16'd0,    16'd0);
		put_item(KIND_START,  3'd1, 16'd0,    16'hBEEF);
		put_item(KIND_SAMPLE, 3'd1, 16'd0,    16'd7);
		put_item(KIND_SAMPLE, 3'd3, 16'd0,    16'hFFFF);
		put_item(KIND_SAMPLE, 3'd2, 16'd0,    16'd0);
		put_item(KIND_SAMPLE, 3'd6, 16'd0,    16'h8001);
		put_item(KIND_SAMPLE, 3'd7, 16'hFFFF, 16'h00FF);
		put_item(KIND_SAMPLE, 3'd0, 16'd100,  16'hFF00);
		put_item(KIND_SAMPLE, 3'd4, 16'hFFFF, 16'h4000);
		put_item(KIND_SAMPLE, 3'd5, 16'd1,    16'h0002);
		put_item(KIND_SAMPLE, 3'd1, 16'd30000, 16'hFFFE);
		put_item(KIND_SPARE,  3'd4, 16'hFFFF, 16'd0);
		put_item(KIND_SAMPLE, 3'd3, 16'd0,    16'hAAAA);
		put_item(KIND_START,  3'd6, 16'd5,    16'h5555);
		put_item(KIND_STOP,   3'd2, 16'd9,    16'hFFFF);
		put_item(KIND_SAMPLE, 3'd5, 16'd77,   16'h1111);
		put_item(KIND_START,  3'd7, 16'd0,    16'd0);
		put_item(KIND_SAMPLE, 3'd2, 16'd1,    16'h5555);
		put_item(KIND_SAMPLE, 3'd3, 16'hFFFF, 16'hAAAA);
		put_item(KIND_SAMPLE, 3'd1, 16'd2,    16'hFFFF);
		put_item(KIND_STOP,   3'd0, 16'd3,    16'd0);
		put_item(KIND_SPARE,  3'd7, 16'd0,    16'hFFFF);
		drain();

		// Random phases, each under its own register setting.
		set_config(16'd0, 16'hFFFF, 1'b0, 8'd0);
		run_motor(100);
		drain();
		set_config(16'hFFFF, 16'd0, 1'b1, 8'd1);
		run_motor(100);
		drain();
		set_config(CMP_W'($urandom), CMP_W'($urandom), 1'($urandom_range(1)),
			8'($urandom_range(5, 2)));
		run_motor(90);
		drain();
		set_config(CMP_W'($urandom), CMP_W'($urandom), 1'b0, 8'd254);
		run_motor(326);
		drain();
		set_config(CMP_W'($urandom), CMP_W'($urandom), 1'($urandom_range(1)), 8'd0);
		run_motor(110);
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
